// ===== sv/mca_pkg.sv =====
`timescale 1ns / 1ps

package mca_pkg;

    localparam int COEFF_BITS_DEF = 32;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } ctrl_t;

endpackage

// ===== sv/mca_red_cell.sv =====
`timescale 1ns / 1ps

module mca_red_cell #(
    parameter int W   = 32,
    parameter int BIT = 31
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [W:0]      q,
    input  mca_pkg::ctrl_t  ctrl_in,
    input  logic [W-1:0]    a_raw_in,
    input  logic [W-1:0]    b_raw_in,
    input  logic [W-1:0]    ra_in,
    input  logic [W-1:0]    rb_in,
    output mca_pkg::ctrl_t  ctrl_out,
    output logic [W-1:0]    a_raw_out,
    output logic [W-1:0]    b_raw_out,
    output logic [W-1:0]    ra_out,
    output logic [W-1:0]    rb_out
);
    import mca_pkg::*;

    ctrl_t        ctrl_reg;
    logic [W-1:0] a_raw_reg;
    logic [W-1:0] b_raw_reg;
    logic [W-1:0] ra_reg;
    logic [W-1:0] rb_reg;
    logic [W-1:0] ra_next;
    logic [W-1:0] rb_next;
    logic [W:0]   xa;
    logic [W:0]   xb;
    logic [W:0]   xa_sub;
    logic [W:0]   xb_sub;

    // shift in one operand bit, subtract q once
    always_comb
    begin
        xa      = {ra_in, a_raw_in[BIT]};
        xb      = {rb_in, b_raw_in[BIT]};
        xa_sub  = xa - q;
        xb_sub  = xb - q;
        ra_next = (xa >= q) ? xa_sub[W-1:0] : xa[W-1:0];
        rb_next = (xb >= q) ? xb_sub[W-1:0] : xb[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_raw_reg <= a_raw_in;
            b_raw_reg <= b_raw_in;
            ra_reg    <= ra_next;
            rb_reg    <= rb_next;
        end
    end

    assign ctrl_out  = ctrl_reg;
    assign a_raw_out = a_raw_reg;
    assign b_raw_out = b_raw_reg;
    assign ra_out    = ra_reg;
    assign rb_out    = rb_reg;

endmodule

// ===== sv/mca_mul_cell.sv =====
`timescale 1ns / 1ps

module mca_mul_cell #(
    parameter int W      = 32,
    parameter int BIT    = 31,
    parameter bit DOUBLE = 1'b1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [W:0]      q,
    input  mca_pkg::ctrl_t  ctrl_in,
    input  logic [W-1:0]    a_in,
    input  logic [W-1:0]    b_in,
    input  logic [W-1:0]    r_in,
    output mca_pkg::ctrl_t  ctrl_out,
    output logic [W-1:0]    a_out,
    output logic [W-1:0]    b_out,
    output logic [W-1:0]    r_out
);
    import mca_pkg::*;

    ctrl_t        ctrl_reg;
    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] r_reg;
    logic [W-1:0] r_next;
    logic [W:0]   x;
    logic [W:0]   x_sub;

    // double the partial result, or add a when this bit of b is set
    always_comb
    begin
        if (DOUBLE)
        begin
            x = {r_in, 1'b0};
        end
        else
        begin
            x = {1'b0, r_in} + (b_in[BIT] ? {1'b0, a_in} : '0);
        end
        x_sub  = x - q;
        r_next = (x >= q) ? x_sub[W-1:0] : x[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_in;
            b_reg <= b_in;
            r_reg <= r_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign a_out    = a_reg;
    assign b_out    = b_reg;
    assign r_out    = r_reg;

endmodule

// ===== sv/modular_coefficient_alu.sv =====
`timescale 1ns / 1ps

// Modular add, subtract and multiply of coefficients modulo the modulus register
// (a written zero means 2^COEFF_BITS). One item enters per cycle while in_stall
// is low, and its residue leaves through: a row of COEFF_BITS cells reduces both
// operands one bit per cell, a row of 2*COEFF_BITS cells runs shift-and-add
// multiplication (one doubling cell and one conditional-add cell per bit of b),
// and a final stage picks the add, subtract or multiply result into the output
// register. A one-entry skid buffer behind the output register lets the row keep
// flowing for one item after out_stall rises; in_stall is high while it is full.
// Write the modulus only while the row is empty. Kind three returns zero.

module modular_coefficient_alu #(
    parameter int COEFF_BITS = mca_pkg::COEFF_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  modulus_we,
    input  logic [COEFF_BITS-1:0] modulus_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            kind,
    input  logic [COEFF_BITS-1:0] operand_a,
    input  logic [COEFF_BITS-1:0] operand_b,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COEFF_BITS-1:0] residue
);
    import mca_pkg::*;

    localparam int W = COEFF_BITS;
    localparam int M = 2 * COEFF_BITS;

    logic [W:0]   q_reg;
    logic [W:0]   q_next;
    logic         en;

    ctrl_t        red_ctrl [0:W];
    logic [W-1:0] red_a_raw [0:W];
    logic [W-1:0] red_b_raw [0:W];
    logic [W-1:0] red_ra [0:W];
    logic [W-1:0] red_rb [0:W];

    ctrl_t        mul_ctrl [0:M];
    logic [W-1:0] mul_a [0:M];
    logic [W-1:0] mul_b [0:M];
    logic [W-1:0] mul_r [0:M];

    logic [W:0]   sum;
    logic [W:0]   sum_sub;
    logic [W:0]   dif_wrap;
    logic [W-1:0] fin;

    logic         out_valid_reg;
    logic         out_valid_next;
    logic [W-1:0] out_data_reg;
    logic [W-1:0] out_data_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    logic [W-1:0] skid_data_reg;
    logic [W-1:0] skid_data_next;

    assign q_next = (modulus_wdata == '0) ? {1'b1, {W{1'b0}}} : {1'b0, modulus_wdata};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= (W+1)'(2);
        end
        else if (modulus_we)
        begin
            q_reg <= q_next;
        end
    end

    // freeze the whole row while the skid buffer holds an item
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    assign red_ctrl[0]  = '{valid: in_valid, kind: kind_t'(kind)};
    assign red_a_raw[0] = operand_a;
    assign red_b_raw[0] = operand_b;
    assign red_ra[0]    = '0;
    assign red_rb[0]    = '0;

    for (genvar s = 0; s < W; s++)
    begin : g_red
        mca_red_cell #(
            .W   (W),
            .BIT (W - 1 - s)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .q         (q_reg),
            .ctrl_in   (red_ctrl[s]),
            .a_raw_in  (red_a_raw[s]),
            .b_raw_in  (red_b_raw[s]),
            .ra_in     (red_ra[s]),
            .rb_in     (red_rb[s]),
            .ctrl_out  (red_ctrl[s+1]),
            .a_raw_out (red_a_raw[s+1]),
            .b_raw_out (red_b_raw[s+1]),
            .ra_out    (red_ra[s+1]),
            .rb_out    (red_rb[s+1])
        );
    end

    assign mul_ctrl[0] = red_ctrl[W];
    assign mul_a[0]    = red_ra[W];
    assign mul_b[0]    = red_rb[W];
    assign mul_r[0]    = '0;

    for (genvar m = 0; m < M; m++)
    begin : g_mul
        localparam int  MBIT = W - 1 - (m / 2);
        localparam bit  MDBL = ((m % 2) == 0);
        mca_mul_cell #(
            .W      (W),
            .BIT    (MBIT),
            .DOUBLE (MDBL)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .q        (q_reg),
            .ctrl_in  (mul_ctrl[m]),
            .a_in     (mul_a[m]),
            .b_in     (mul_b[m]),
            .r_in     (mul_r[m]),
            .ctrl_out (mul_ctrl[m+1]),
            .a_out    (mul_a[m+1]),
            .b_out    (mul_b[m+1]),
            .r_out    (mul_r[m+1])
        );
    end

    // pick the result of the requested operation
    always_comb
    begin
        sum      = {1'b0, mul_a[M]} + {1'b0, mul_b[M]};
        sum_sub  = sum - q_reg;
        dif_wrap = ({1'b0, mul_a[M]} + q_reg) - {1'b0, mul_b[M]};
        case (mul_ctrl[M].kind)
            KIND_ADD:
            begin
                fin = (sum >= q_reg) ? sum_sub[W-1:0] : sum[W-1:0];
            end
            KIND_SUB:
            begin
                fin = (mul_a[M] >= mul_b[M]) ? (mul_a[M] - mul_b[M]) : dif_wrap[W-1:0];
            end
            KIND_MUL:
            begin
                fin = mul_r[M];
            end
            default:
            begin
                fin = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_next = mul_ctrl[M].valid;
            out_data_next  = fin;
        end
        else if (mul_ctrl[M].valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign residue   = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer full with empty output register");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("skid item lost while output stalled");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled output item dropped or changed");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid buffer filled without an output stall");

endmodule
